/* hw/rtl/mavg_pkg.sv */
// Shared types and constants for the moving average filter.
// No dependencies; imported by moving_average_filter_core.
`timescale 1ns / 1ps

package mavg_pkg;

    // Window length register
    localparam int          WIN_W     = 9;
    localparam logic [8:0]  WIN_RESET = 9'd16;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SUB   = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_PREP  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } mavg_state_t;

endpackage

/* hw/rtl/moving_average_filter_core.sv */
// Boxcar moving average: sample ring, running sum and a bit-serial divider.
// Depends on mavg_pkg.
`timescale 1ns / 1ps

// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// sample    | sample_valid, sample_ready, sample        | in
// average   | average_valid, average_ready, average     | out
// config    | cfg_wr_en, cfg_wr_data (window length)    | in
//
// Each item passes through accept, ring read and subtract, add and ring write,
// magnitude, SUM_W restoring divide steps through one shared subtractor, then
// sign/saturate into the output register; no new item is accepted until it is
// done. After reset the ring is cleared one entry a cycle; no item is accepted
// meanwhile. A stalled output holds the next result in the final stage until
// the output register frees up.

module moving_average_filter_core
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
)(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,

    output logic                          average_valid,
    input  logic                          average_ready,
    output logic signed [SAMPLE_BITS-1:0] average,

    input  logic                          cfg_wr_en,
    input  logic        [WIN_W-1:0]       cfg_wr_data
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = PTR_W + 1;
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int EXT_W  = SUM_W - SAMPLE_BITS;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [PTR_W-1:0]       PTR_LAST = PTR_W'(MAX_WINDOW - 1);
    localparam logic [SUM_W-1:0]       HALF_MAG = SUM_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] AVG_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] AVG_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Control state
    mavg_state_t              state_reg,   state_next;
    logic [PTR_W-1:0]         wp_reg,      wp_next;
    logic signed [SUM_W-1:0]  sum_reg,     sum_next;
    logic [WIN_W-1:0]         win_len_reg, win_len_next;
    logic [STEP_W-1:0]        step_reg,    step_next;
    logic                     out_vld_reg, out_vld_next;

    // Payload
    logic signed [SAMPLE_BITS-1:0] smp_reg,  smp_next;
    logic [CNT_W-1:0]              len_reg,  len_next;
    logic [SUM_W-1:0]              dvd_reg,  dvd_next;
    logic [CNT_W-1:0]              rem_reg,  rem_next;
    logic                          neg_reg,  neg_next;
    logic [SAMPLE_BITS-1:0]        avg_reg,  avg_next;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

    logic                   accept;
    logic                   ring_we;
    logic [SAMPLE_BITS-1:0] ring_wdata;
    logic [CMP_W-1:0]       cfg_ext;
    logic [CNT_W-1:0]       eff_len;
    logic [CNT_W-1:0]       wp_inc;
    logic [PTR_W-1:0]       pos_calc;
    logic [CNT_W:0]         shifted;
    logic [CNT_W+1:0]       diff;
    logic                   out_free;

    assign sample_ready  = (state_reg == ST_IDLE);
    assign accept        = sample_valid && sample_ready;
    assign average_valid = out_vld_reg;
    assign average       = avg_reg;
    assign out_free      = !out_vld_reg || average_ready;

    // Effective window: zero reads as one, anything above the ring saturates
    always_comb
    begin
        cfg_ext = CMP_W'(win_len_reg);
        if (win_len_reg == '0)
            eff_len = CNT_W'(1);
        else if (cfg_ext > CMP_W'(MAX_WINDOW))
            eff_len = CNT_W'(MAX_WINDOW);
        else
            eff_len = CNT_W'(win_len_reg);
    end

    assign wp_inc   = {1'b0, wp_reg} + CNT_W'(1);
    assign pos_calc = (wp_inc >= eff_len) ? '0 : wp_inc[PTR_W-1:0];

    // One restoring divide step
    assign shifted = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, len_reg};

    assign ring_we    = (state_reg == ST_CLEAR) || (state_reg == ST_ADD);
    assign ring_wdata = (state_reg == ST_CLEAR) ? '0 : smp_reg;

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        sum_next     = sum_reg;
        win_len_next = cfg_wr_en ? cfg_wr_data : win_len_reg;
        step_next    = step_reg;
        out_vld_next = out_vld_reg && !average_ready;
        smp_next     = smp_reg;
        len_next     = len_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        avg_next     = avg_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                if (wp_reg == PTR_LAST)
                begin
                    wp_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wp_next = wp_reg + PTR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    smp_next   = sample;
                    len_next   = eff_len;
                    wp_next    = pos_calc;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                sum_next   = sum_reg - {{EXT_W{rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                sum_next   = sum_reg + {{EXT_W{smp_reg[SAMPLE_BITS-1]}}, smp_reg};
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                neg_next   = sum_reg[SUM_W-1];
                dvd_next   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                rem_next   = '0;
                step_next  = STEP_W'(SUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!diff[CNT_W+1])
                begin
                    rem_next = diff[CNT_W-1:0];
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[CNT_W-1:0];
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                end
                if (step_reg == '0)
                    state_next = ST_OUT;
                else
                    step_next = step_reg - STEP_W'(1);
            end
            ST_OUT:
            begin
                // dvd_reg now holds the quotient magnitude
                if (out_free)
                begin
                    if (neg_reg)
                        avg_next = (dvd_reg > HALF_MAG) ? AVG_MIN
                                 : SAMPLE_BITS'(-dvd_reg[SAMPLE_BITS-1:0]);
                    else
                        avg_next = (dvd_reg >= HALF_MAG) ? AVG_MAX
                                 : dvd_reg[SAMPLE_BITS-1:0];
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            wp_reg      <= '0;
            sum_reg     <= '0;
            win_len_reg <= WIN_RESET;
            step_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            sum_reg     <= sum_next;
            win_len_reg <= win_len_next;
            step_reg    <= step_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        len_reg <= len_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        avg_reg <= avg_next;
    end

    // Sample ring: one write port, one registered read at the next position
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wp_reg] <= ring_wdata;
        if (accept)
            rd_data_reg <= ring_mem[pos_calc];
    end

    // Checks
    a_accept_to_sub: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SUB)
        else $error("accepted item did not start the update");

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |-> ##(SUM_W + 1) state_reg == ST_OUT)
        else $error("divide did not finish in SUM_W steps");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(average_valid) |-> $past(state_reg == ST_OUT))
        else $error("result shown without passing the output stage");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> !average_valid)
        else $error("result appeared during ring clear");

endmodule
